// ----- src/fpab_pkg.sv -----
// Package for the binary16 broadcast adder: widths, request and register codes and the adder function.
// Depends on nothing.
package fpab_pkg;

  localparam int unsigned MaxRowDefault = 1024;
  localparam int unsigned HalfW         = 16;
  localparam int unsigned RowLenW       = 11;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_OPERAND = 1'b1
  } req_type_e;

  typedef enum logic [0:0] {
    REG_ROW_LENGTH = 1'b0
  } reg_idx_e;

  function automatic logic [15:0] fp16_add(input logic [15:0] a, input logic [15:0] b);
    logic [14:0] aa, ab, tt;
    logic        sa, sb, ts;
    logic [5:0]  ea, eb, e;
    logic [13:0] ma, mb;
    logic [4:0]  d;
    logic [14:0] r;
    logic [2:0]  grs;
    logic [11:0] m;
    logic [4:0]  lz;
    logic [27:0] ext;
    logic        stk;
    logic [15:0] res;
    aa = a[14:0];
    ab = b[14:0];
    sa = a[15];
    sb = b[15];
    res = 16'h0000;
    if (aa > 15'h7C00) begin
      res = a | 16'h0200;
    end else if (ab > 15'h7C00) begin
      res = b | 16'h0200;
    end else if (aa == 15'h7C00) begin
      res = (ab == 15'h7C00 && sa != sb) ? 16'h7E00 : a;
    end else if (ab == 15'h7C00) begin
      res = b;
    end else begin
      if (ab > aa) begin
        tt = aa; aa = ab; ab = tt;
        ts = sa; sa = sb; sb = ts;
      end
      ea = {1'b0, aa[14:10]};
      eb = {1'b0, ab[14:10]};
      ma = {3'b000, aa[9:0], 1'b0};
      mb = {3'b000, ab[9:0], 1'b0};
      ma = {3'b000, (ea != 6'd0), aa[9:0]} << 3;
      mb = {3'b000, (eb != 6'd0), ab[9:0]} << 3;
      if (ea == 6'd0) ea = 6'd1;
      if (eb == 6'd0) eb = 6'd1;
      d = 5'(ea - eb);
      if (d >= 5'd20) begin
        mb = {13'd0, (mb != 14'd0)};
      end else begin
        ext = {mb, 14'd0} >> d;
        stk = (ext[13:0] != 14'd0);
        mb = ext[27:14] | {13'd0, stk};
      end
      e = ea;
      if (sa == sb) r = {1'b0, ma} + {1'b0, mb};
      else          r = {1'b0, ma} - {1'b0, mb};
      if (r == 15'd0) begin
        res = (sa == sb) ? {sa, 15'd0} : 16'h0000;
      end else begin
        if (r >= 15'h4000) begin
          r = {1'b0, r[14:1]} | {14'd0, r[0]};
          e = e + 6'd1;
        end
        lz = 5'd0;
        for (int i = 13; i >= 0; i--) begin
          if (r[i] && lz == 5'd0) lz = 5'(13 - i);
        end
        if (r[13]) lz = 5'd0;
        if ({1'b0, lz} > e - 6'd1) lz = 5'(e - 6'd1);
        r = r << lz;
        e = e - {1'b0, lz};
        grs = r[2:0];
        m = r[14:3];
        if (grs > 3'd4 || (grs == 3'd4 && m[0])) m = m + 12'd1;
        if (m >= 12'h800) begin
          m = m >> 1;
          e = e + 6'd1;
        end
        if (e >= 6'd31)        res = {sa, 15'h7C00};
        else if (m < 12'h400)  res = {sa, 5'd0, m[9:0]};
        else                   res = {sa, e[4:0], m[9:0]};
      end
    end
    return res;
  endfunction

endpackage

// ----- src/fpab_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
module fpab_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- src/fp16_add_broadcast.sv -----
// Top level of the binary16 broadcast adder: APB register, row store, adder and output stage.
// Depends on fpab_pkg and fpab_ram.
//
// Channel  | Dir | Handshake        | Payload
// s_axis   | in  | tvalid/tready    | tdata {b_half,a_half}, tuser req_type
// m_axis   | out | tvalid/tready    | tdata sum_half, tlast row_end
// apb      | in  | psel/penable     | row_length at 0x0
//
// One word per cycle unless m_axis stalls; operand sums leave via stages one and two.
// Stage one reads the row store, stage two adds and holds the result.
// A stall at the output holds both stages; the input is taken when stage one can advance.
// Reset clears pointers, row_length and valid flags; the row store is not cleared.
module fp16_add_broadcast
  import fpab_pkg::*;
#(
  parameter int unsigned MaxRow = MaxRowDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // a_half[15:0], b_half[31:16]
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // sum_half
  output logic        m_axis_tlast,  // row_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AddrW = (MaxRow > 1) ? $clog2(MaxRow) : 1;
  localparam int unsigned PtrW  = $clog2(MaxRow + 1);
  localparam int unsigned LenW  = (PtrW > RowLenW) ? PtrW : RowLenW;

  logic [RowLenW-1:0] row_len_q;
  logic [PtrW-1:0]    load_ptr_q, load_ptr_d, col_q, col_d;
  logic [LenW-1:0]    eff_len;
  logic               cfg_we, acc, s1_adv, out_adv;
  logic               s1_vld_q, s1_last_q, s1_bc_q;
  logic [15:0]        s1_a_q, s1_b_q, rd_data, s1_op_b;
  logic               o_vld_q, o_last_q;
  logic [15:0]        o_sum_q;
  logic [PtrW-1:0]    ld_idx, rd_idx;
  logic               bc_mode, is_op, ld_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ROW_LENGTH);
  assign prdata = (paddr[2] == REG_ROW_LENGTH) ? {{(32-RowLenW){1'b0}}, row_len_q} : 32'd0;

  assign eff_len = (LenW'(row_len_q) > LenW'(MaxRow)) ? LenW'(MaxRow) : LenW'(row_len_q);
  assign bc_mode = (eff_len != '0);

  assign out_adv       = !o_vld_q || m_axis_tready;
  assign s1_adv        = !s1_vld_q || out_adv;
  assign s_axis_tready = s1_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign is_op         = (s_axis_tuser == REQ_OPERAND);

  assign ld_idx = (LenW'(load_ptr_q) >= eff_len) ? '0 : load_ptr_q;
  assign rd_idx = (LenW'(col_q) >= eff_len) ? '0 : col_q;
  assign ld_we  = acc && !is_op && bc_mode;

  always_comb begin
    load_ptr_d = load_ptr_q;
    col_d      = col_q;
    if (ld_we) begin
      load_ptr_d = (LenW'(ld_idx) + LenW'(1) >= eff_len) ? '0 : ld_idx + PtrW'(1);
    end
    if (acc && is_op && bc_mode) begin
      col_d = (LenW'(rd_idx) + LenW'(1) >= eff_len) ? '0 : rd_idx + PtrW'(1);
    end
    if (cfg_we) begin
      load_ptr_d = '0;
      col_d      = '0;
    end
  end

  fpab_ram #(.Width(HalfW), .Depth(MaxRow)) u_row (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_idx[AddrW-1:0]),
    .wdata_i (s_axis_tdata[31:16]),
    .re_i    (acc && is_op && bc_mode),
    .raddr_i (rd_idx[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q  <= '0;
      load_ptr_q <= '0;
      col_q      <= '0;
      s1_vld_q   <= 1'b0;
      o_vld_q    <= 1'b0;
    end else begin
      if (cfg_we) row_len_q <= pwdata[RowLenW-1:0];
      load_ptr_q <= load_ptr_d;
      col_q      <= col_d;
      if (s1_adv) s1_vld_q <= acc && is_op;
      if (out_adv) o_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && s1_adv) begin
      s1_a_q    <= s_axis_tdata[15:0];
      s1_b_q    <= s_axis_tdata[31:16];
      s1_bc_q   <= bc_mode;
      s1_last_q <= bc_mode && (LenW'(rd_idx) + LenW'(1) >= eff_len);
    end
    if (out_adv && s1_vld_q) begin
      o_sum_q  <= fp16_add(s1_a_q, s1_op_b);
      o_last_q <= s1_last_q;
    end
  end

  assign s1_op_b       = s1_bc_q ? rd_data : s1_b_q;
  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = o_sum_q;
  assign m_axis_tlast  = o_last_q;
endmodule

// ----- src/fpab_checker.sv -----
// Port-level checker for the binary16 broadcast adder, bound to the top level.
// Depends on fpab_pkg.
module fpab_checker
  import fpab_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        pready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_LOAD && !m_axis_tvalid
    |=> ##1 !m_axis_tvalid || $past(m_axis_tvalid) || $past(s_axis_tvalid, 1))
    else $error("load word produced a result");
  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");
endmodule

bind fp16_add_broadcast fpab_checker u_fpab_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

// ----- verif/fp16_add_broadcast_tb.sv -----
// Testbench for fp16_add_broadcast: drives operand and load words, writes row_length over APB,
// and checks every sum against a local binary16 adder with broadcast row tracking.
// Depends on fpab_pkg and the RTL of the block.
module fp16_add_broadcast_tb;
  import fpab_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] sum;
    logic        row_end;
  } sum_word_t;

  typedef struct {
    req_type_e   req;
    logic [15:0] a;
    logic [15:0] b;
    logic        has_exp;
    logic [15:0] exp_sum;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fp16_add_broadcast u_dut (.*);

  always #5 clk_i = ~clk_i;

  logic [15:0] row_vec [1024];
  int unsigned cfg_len, load_ptr, col_idx;
  sum_word_t   sum_q [$];
  int unsigned mismatches = 0;
  bit          quiet_out = 1'b0;

  function automatic logic [15:0] shift_sticky(logic [15:0] v, int unsigned d);
    if (d == 0) return v;
    if (d >= 16) return {15'd0, v != 0};
    return (v >> d) | {15'd0, (v & ((16'd1 << d) - 16'd1)) != 0};
  endfunction

  function automatic logic [15:0] half_add(logic [15:0] a, logic [15:0] b);
    logic [14:0] xa, xb, t;
    logic        sa, sb, ts;
    int unsigned ea, eb, e;
    logic [15:0] ma, mb, r;
    logic [11:0] m;
    logic [2:0]  g;
    xa = a[14:0]; xb = b[14:0]; sa = a[15]; sb = b[15];
    if (xa > 15'h7C00) return a | 16'h0200;
    if (xb > 15'h7C00) return b | 16'h0200;
    if (xa == 15'h7C00) return (xb == 15'h7C00 && sa != sb) ? 16'h7E00 : a;
    if (xb == 15'h7C00) return b;
    if (xb > xa) begin
      t = xa; xa = xb; xb = t; ts = sa; sa = sb; sb = ts;
    end
    ea = xa[14:10]; eb = xb[14:10];
    ma = {5'd0, ea != 0, xa[9:0]} << 3;
    mb = {5'd0, eb != 0, xb[9:0]} << 3;
    if (ea == 0) ea = 1;
    if (eb == 0) eb = 1;
    mb = shift_sticky(mb, ea - eb);
    e = ea;
    if (sa == sb) r = ma + mb;
    else begin
      r = ma - mb;
      if (r == 0) return 16'h0000;
    end
    if (r == 0) return {sa, 15'd0};
    if (r >= 16'h4000) begin
      r = shift_sticky(r, 1);
      e++;
    end
    while (r < 16'h2000 && e > 1) begin
      r = r << 1;
      e--;
    end
    g = r[2:0];
    m = r[14:3];
    if (g > 3'd4 || (g == 3'd4 && m[0])) m++;
    if (m >= 12'h800) begin
      m = m >> 1;
      e++;
    end
    if (e >= 31) return {sa, 15'h7C00};
    if (m < 12'h400) return {sa, 5'd0, m[9:0]};
    return {sa, e[4:0], m[9:0]};
  endfunction

  function automatic int unsigned eff_len();
    return cfg_len > 1024 ? 1024 : cfg_len;
  endfunction

  // advance the row model and, for an operand word, queue the expected sum
  function automatic void predict_sum(req_type_e req, logic [15:0] a, logic [15:0] b);
    int unsigned len;
    sum_word_t   w;
    len = eff_len();
    if (req == REQ_LOAD) begin
      if (len == 0) return;
      if (load_ptr >= len) load_ptr = 0;
      row_vec[load_ptr] = b;
      load_ptr++;
      if (load_ptr >= len) load_ptr = 0;
      return;
    end
    if (len == 0) begin
      w.sum = half_add(a, b);
      w.row_end = 1'b0;
    end else begin
      if (col_idx >= len) col_idx = 0;
      w.sum = half_add(a, row_vec[col_idx]);
      w.row_end = (col_idx + 1 >= len);
      col_idx = w.row_end ? 0 : col_idx + 1;
    end
    sum_q.push_back(w);
  endfunction

  function automatic bit idle_now();
    return !quiet_out && ($urandom_range(99) < 9);
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cfg_len = val & 32'h7FF;
    load_ptr = 0;
    col_idx = 0;
  endtask

  task automatic send_word(req_type_e req, logic [15:0] a, logic [15:0] b);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sum(req, a, b);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sum_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected sum %h last %b", m_axis_tdata, m_axis_tlast);
        end else begin
          sum_word_t w;
          w = sum_q.pop_front();
          if (w.sum !== m_axis_tdata || w.row_end !== m_axis_tlast) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sum mismatch: exp %h/%b got %h/%b", w.sum, w.row_end,
                       m_axis_tdata, m_axis_tlast);
          end
        end
      end
      m_axis_tready <= !idle_now();
    end
  end

  function automatic logic [15:0] rand_half();
    case ($urandom_range(7))
      0: return {1'($urandom_range(1)), 15'h7C00};
      1: return {1'($urandom_range(1)), 5'd0, 10'($urandom)};
      2: return {1'($urandom_range(1)), 5'h1F, 10'($urandom)};
      3: return {1'($urandom_range(1)), 5'($urandom_range(28, 30)), 10'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    static stim_row_t dir_tab[] = '{
      '{REQ_OPERAND, 16'h0000, 16'h0000, 1, 16'h0000},
      '{REQ_OPERAND, 16'h8000, 16'h8000, 1, 16'h8000},
      '{REQ_OPERAND, 16'h8000, 16'h0000, 1, 16'h0000},
      '{REQ_OPERAND, 16'h3C00, 16'hBC00, 1, 16'h0000},
      '{REQ_OPERAND, 16'h3C00, 16'h3C00, 1, 16'h4000},
      '{REQ_OPERAND, 16'h7C00, 16'hFC00, 1, 16'h7E00},
      '{REQ_OPERAND, 16'h7C00, 16'h3C00, 1, 16'h7C00},
      '{REQ_OPERAND, 16'h7C01, 16'h7D00, 1, 16'h7E01},
      '{REQ_OPERAND, 16'h3C00, 16'hFC01, 1, 16'hFE01},
      '{REQ_OPERAND, 16'h7BFF, 16'h7BFF, 1, 16'h7C00},
      '{REQ_OPERAND, 16'hFBFF, 16'hFBFF, 1, 16'hFC00},
      '{REQ_OPERAND, 16'h0001, 16'h0001, 1, 16'h0002},
      '{REQ_OPERAND, 16'h03FF, 16'h0001, 1, 16'h0400},
      '{REQ_OPERAND, 16'h3C00, 16'h0001, 0, 16'h0000},
      '{REQ_OPERAND, 16'hFFFF, 16'hFFFF, 0, 16'h0000},
      '{REQ_LOAD,    16'h1234, 16'h5678, 0, 16'h0000}
    };
    static int unsigned lens[] = '{1, 3, 2047, 5, 0, 17};
    int unsigned len, cnt, fill;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    cfg_len = 0; load_ptr = 0; col_idx = 0;
    @(posedge clk_i);
    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].req, dir_tab[i].a, dir_tab[i].b);
      if (dir_tab[i].has_exp && sum_q[$].sum !== dir_tab[i].exp_sum) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d: model %h", i, sum_q[$].sum);
      end
    end
    drain();
    // broadcast phases: fill the row (only its head when long), then operand words with occasional load words
    foreach (lens[k]) begin
      apb_write(REG_ROW_LENGTH, lens[k]);
      len = eff_len();
      quiet_out = (k == 2);
      if (len != 0) begin
        fill = (len > 100) ? 100 : len;
        for (int i = 0; i < fill; i++) send_word(REQ_LOAD, 16'($urandom), rand_half());
        cnt = (len > 100) ? 80 : 130;
      end else cnt = 130;
      for (int i = 0; i < cnt; i++) begin
        if (len != 0 && $urandom_range(9) == 0) send_word(REQ_LOAD, 16'($urandom), rand_half());
        else send_word(REQ_OPERAND, rand_half(), rand_half());
        if (i == cnt / 2 && k == 4) drain();
      end
      drain();
    end
    quiet_out = 1'b0;
    drain();
    if (mismatches == 0 && sum_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ----- sim.f -----
src/fpab_pkg.sv
src/fpab_ram.sv
src/fp16_add_broadcast.sv
src/fpab_checker.sv
verif/fp16_add_broadcast_tb.sv
